// ----- rtl/bctm_pkg.sv -----
package bctm_pkg;

	localparam int NUM_BUFFERS = 32;
	localparam int IDX_W = $clog2(NUM_BUFFERS);
	localparam int CNT_W = $clog2(NUM_BUFFERS + 1);

	localparam logic [2:0] OP_GET = 3'd0;
	localparam logic [2:0] OP_LOOKUP = 3'd1;
	localparam logic [2:0] OP_RELEASE = 3'd2;
	localparam logic [2:0] OP_UPDATE = 3'd3;
	localparam logic [2:0] OP_SYNC = 3'd4;

	localparam logic [3:0] ST_HIT = 4'd0;
	localparam logic [3:0] ST_ALLOC = 4'd1;
	localparam logic [3:0] ST_MISS = 4'd2;
	localparam logic [3:0] ST_NOFREE = 4'd3;
	localparam logic [3:0] ST_VDIRTY = 4'd4;
	localparam logic [3:0] ST_VLOCKED = 4'd5;
	localparam logic [3:0] ST_RELEASED = 4'd6;
	localparam logic [3:0] ST_RELERR = 4'd7;
	localparam logic [3:0] ST_FLAGS = 4'd8;
	localparam logic [3:0] ST_WRITEBACK = 4'd9;

	typedef struct packed {
		logic [2:0] opcode;
		logic [15:0] device;
		logic [31:0] block_number;
		logic [4:0] buffer_index;
		logic new_dirty;
		logic new_locked;
		logic new_uptodate;
	} req_t;

	typedef struct packed {
		logic [3:0] status;
		logic [4:0] entry_index;
		logic [15:0] entry_device;
		logic uptodate;
		logic locked;
		logic wake;
		logic last;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic load;       // capture request, reset walk
		logic step;       // advance walk by one entry
		logic lookup_end; // finish hit/miss search
		logic scan;       // victim scan: fold current entry into best
		logic alloc;      // retag victim, move to tail
		logic single;     // release/update/error response
		logic sync_emit;  // emit writeback for current entry if dirty match
		logic flush;      // emit held writeback as the final one
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic hit_found;
		logic walk_done;
		logic stop_early;
		logic found;
	} sts_t;

endpackage

// ----- rtl/bctm_ctrl.sv -----
module bctm_ctrl
	import bctm_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [2:0] opcode,
	input sts_t sts,
	output logic busy,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE, S_SEARCH, S_SCAN, S_DECIDE, S_SINGLE, S_SYNC, S_FLUSH
	} state_t;

	state_t state_q;

	always_comb begin
		cmd = '0;
		cmd.load = start && !busy;
		case (state_q)
			S_SEARCH: begin
				cmd.step = !sts.walk_done && !sts.hit_found;
				cmd.lookup_end = sts.walk_done || sts.hit_found;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				cmd.step = !sts.walk_done && !sts.stop_early;
			end
			S_DECIDE: cmd.alloc = 1'b1;
			S_SINGLE: cmd.single = 1'b1;
			S_SYNC: begin
				cmd.sync_emit = 1'b1;
				cmd.step = 1'b1;
			end
			S_FLUSH: cmd.flush = 1'b1;
			default: ;
		endcase
	end

	assign busy = state_q != S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (start) begin
					case (opcode)
						OP_GET, OP_LOOKUP: state_q <= S_SEARCH;
						OP_RELEASE, OP_UPDATE: state_q <= S_SINGLE;
						OP_SYNC: state_q <= S_SYNC;
						default: state_q <= S_IDLE;
					endcase
				end
				S_SEARCH: if (cmd.lookup_end) begin
					// datapath reports hit/miss itself; only a get miss scans
					state_q <= (sts.found) ? S_SCAN : S_IDLE;
				end
				S_SCAN: if (sts.walk_done || sts.stop_early) state_q <= S_DECIDE;
				S_DECIDE: state_q <= S_IDLE;
				S_SINGLE: state_q <= S_IDLE;
				S_SYNC: if (sts.walk_done) state_q <= S_FLUSH;
				S_FLUSH: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/bctm_dp.sv -----
module bctm_dp
	import bctm_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input req_t req,
	input cmd_t cmd,
	output sts_t sts,
	output logic result_valid,
	output rsp_t result
);

	logic [15:0] tdev_q [NUM_BUFFERS];
	logic [31:0] tblk_q [NUM_BUFFERS];
	logic [7:0] cnt_q [NUM_BUFFERS];
	logic [NUM_BUFFERS-1:0] dirty_q, lock_q, upd_q;
	logic [IDX_W-1:0] nxt_q [NUM_BUFFERS];
	logic [IDX_W-1:0] prv_q [NUM_BUFFERS];
	logic [IDX_W-1:0] head_q;

	req_t r_q;
	logic [IDX_W-1:0] cur_q, best_q;
	logic [CNT_W-1:0] n_q;
	logic found_q;
	logic [1:0] bbad_q;
	logic pend_q;          // a writeback already held, waiting for next
	rsp_t pend_rsp_q;

	logic [1:0] bad_cur;
	logic match, is_get, cand, better;
	logic [IDX_W-1:0] bi;
	logic bi_ok;
	logic alloc_ok;
	logic sync_hit;
	logic [IDX_W-1:0] hd, hp, vn, vp;
	logic valid_nx;
	rsp_t rsp_nx;

	function automatic rsp_t ent(input logic [3:0] st, input logic [IDX_W-1:0] i,
		input logic [15:0] d, input logic u, input logic l);
		rsp_t x;
		x.status = st;
		x.entry_index = 5'(i);
		x.entry_device = d;
		x.uptodate = u;
		x.locked = l;
		x.wake = 1'b0;
		x.last = 1'b1;
		return x;
	endfunction

	assign bad_cur = {dirty_q[cur_q], lock_q[cur_q]};
	assign match = tdev_q[cur_q] == r_q.device && tblk_q[cur_q] == r_q.block_number
		&& r_q.device != 16'd0;
	assign is_get = r_q.opcode == OP_GET && r_q.device != 16'd0;
	assign cand = cnt_q[cur_q] == 8'd0;
	assign better = cand && (!found_q || bad_cur < bbad_q);
	assign bi = r_q.buffer_index[IDX_W-1:0];
	assign bi_ok = {1'b0, r_q.buffer_index} < 6'(NUM_BUFFERS);
	assign alloc_ok = cmd.alloc && found_q && !lock_q[best_q] && !dirty_q[best_q];

	assign sts.walk_done = n_q == CNT_W'(NUM_BUFFERS - 1) && !cmd.load;
	assign sts.hit_found = match;
	assign sts.stop_early = better && bad_cur == 2'd0;
	// in search: found means "go scan" (miss on a real get)
	assign sts.found = !match && is_get;

	assign sync_hit = dirty_q[cur_q] && (r_q.device == 16'd0 || tdev_q[cur_q] == r_q.device);
	// victim unlink, then new head and the entry before it once unlinked
	assign vn = nxt_q[best_q];
	assign vp = prv_q[best_q];
	assign hd = (head_q == best_q) ? vn : head_q;
	assign hp = (head_q == best_q) ? vp : ((prv_q[head_q] == best_q) ? vp
		: prv_q[head_q]);

	// walk position and captured request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q <= '0;
			cur_q <= '0;
			n_q <= '0;
		end else if (cmd.load) begin
			r_q <= req;
			cur_q <= '0;
			n_q <= '0;
		end else if (cmd.lookup_end) begin
			// get miss: ring scan starts from head
			if (is_get && !match) begin
				cur_q <= head_q;
				n_q <= '0;
			end
		end else if (cmd.step) begin
			cur_q <= (r_q.opcode == OP_SYNC) ? IDX_W'(cur_q + 1'b1) : nxt_q[cur_q];
			n_q <= n_q + 1'b1;
		end
	end

	// victim selection
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			best_q <= '0;
			bbad_q <= '0;
		end else if (cmd.load || cmd.lookup_end) begin
			found_q <= 1'b0;
		end else if (cmd.scan && better) begin
			best_q <= cur_q;
			bbad_q <= bad_cur;
			found_q <= 1'b1;
		end
	end

	// sync: hold one writeback back so the final one can carry last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			pend_rsp_q <= '0;
		end else if (cmd.load || cmd.flush) begin
			pend_q <= 1'b0;
		end else if (cmd.sync_emit && sync_hit) begin
			pend_q <= 1'b1;
			pend_rsp_q <= ent(ST_WRITEBACK, cur_q, tdev_q[cur_q], upd_q[cur_q],
				lock_q[cur_q]);
		end
	end

	always_comb begin
		valid_nx = 1'b0;
		rsp_nx = ent(ST_MISS, '0, '0, 1'b0, 1'b0);
		if (cmd.lookup_end) begin
			if (match) begin
				valid_nx = 1'b1;
				rsp_nx = ent(ST_HIT, cur_q, tdev_q[cur_q], upd_q[cur_q], lock_q[cur_q]);
			end else if (!is_get) begin
				valid_nx = 1'b1;
			end
		end
		if (cmd.alloc) begin
			valid_nx = 1'b1;
			if (!found_q) begin
				rsp_nx = ent(ST_NOFREE, '0, '0, 1'b0, 1'b0);
			end else if (lock_q[best_q]) begin
				rsp_nx = ent(ST_VLOCKED, best_q, tdev_q[best_q], upd_q[best_q], 1'b1);
			end else if (dirty_q[best_q]) begin
				rsp_nx = ent(ST_VDIRTY, best_q, tdev_q[best_q], upd_q[best_q], 1'b0);
			end else begin
				rsp_nx = ent(ST_ALLOC, best_q, r_q.device, 1'b0, 1'b0);
			end
		end
		if (cmd.single) begin
			valid_nx = 1'b1;
			if (!bi_ok) begin
				rsp_nx = ent(ST_RELERR, '0, '0, 1'b0, 1'b0);
				rsp_nx.entry_index = r_q.buffer_index;
			end else if (r_q.opcode == OP_RELEASE) begin
				if (cnt_q[bi] == 8'd0) begin
					rsp_nx = ent(ST_RELERR, bi, tdev_q[bi], upd_q[bi], lock_q[bi]);
				end else begin
					rsp_nx = ent(ST_RELEASED, bi, tdev_q[bi], upd_q[bi], lock_q[bi]);
					rsp_nx.wake = cnt_q[bi] == 8'd1;
				end
			end else begin
				rsp_nx = ent(ST_FLAGS, bi, tdev_q[bi], r_q.new_uptodate, r_q.new_locked);
			end
		end
		// a newer hit proves the held one is not the final writeback
		if (cmd.sync_emit && sync_hit && pend_q) begin
			valid_nx = 1'b1;
			rsp_nx = pend_rsp_q;
			rsp_nx.last = 1'b0;
		end
		if (cmd.flush && pend_q) begin
			valid_nx = 1'b1;
			rsp_nx = pend_rsp_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
			result <= '0;
		end else begin
			result_valid <= valid_nx;
			result <= rsp_nx;
		end
	end

	// reference counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BUFFERS; i++)
				cnt_q[i] <= '0;
		end else if (cmd.lookup_end && match) begin
			if (cnt_q[cur_q] != 8'hff) cnt_q[cur_q] <= cnt_q[cur_q] + 8'd1;
		end else if (alloc_ok) begin
			cnt_q[best_q] <= 8'd1;
		end else if (cmd.single && bi_ok && r_q.opcode == OP_RELEASE
			&& cnt_q[bi] != 8'd0) begin
			cnt_q[bi] <= cnt_q[bi] - 8'd1;
		end
	end

	// flags; an allocated victim is already clean and unlocked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dirty_q <= '0;
			lock_q <= '0;
			upd_q <= '0;
		end else if (alloc_ok) begin
			upd_q[best_q] <= 1'b0;
		end else if (cmd.single && bi_ok && r_q.opcode == OP_UPDATE) begin
			dirty_q[bi] <= r_q.new_dirty;
			lock_q[bi] <= r_q.new_locked;
			upd_q[bi] <= r_q.new_uptodate;
		end
	end

	// tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BUFFERS; i++) begin
				tdev_q[i] <= '0;
				tblk_q[i] <= '0;
			end
		end else if (alloc_ok) begin
			tdev_q[best_q] <= r_q.device;
			tblk_q[best_q] <= r_q.block_number;
		end
	end

	// recency ring: unlink victim and reinsert it just before the head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BUFFERS; i++) begin
				nxt_q[i] <= IDX_W'((i + 1) % NUM_BUFFERS);
				prv_q[i] <= IDX_W'((i + NUM_BUFFERS - 1) % NUM_BUFFERS);
			end
			head_q <= '0;
		end else if (alloc_ok) begin
			for (int i = 0; i < NUM_BUFFERS; i++) begin
				if (IDX_W'(i) == hp) nxt_q[i] <= best_q;
				else if (IDX_W'(i) == best_q) nxt_q[i] <= hd;
				else if (IDX_W'(i) == vp) nxt_q[i] <= vn;
				if (IDX_W'(i) == hd) prv_q[i] <= best_q;
				else if (IDX_W'(i) == best_q) prv_q[i] <= hp;
				else if (IDX_W'(i) == vn) prv_q[i] <= vp;
			end
			head_q <= hd;
		end
	end

endmodule

// ----- rtl/buffer_cache_tag_manager.sv -----
// Buffer cache tag manager. Pulse start while busy is low to issue one item
// (get, lookup, release, flag update, sync). Results appear on result with
// result_valid high for exactly one cycle; the receiver cannot stall, so it
// must take every strobe. Release and update answer without a walk; a hit or
// lookup searches the tag store one entry a cycle, a get miss searches, then
// walks the ring from the head one entry a cycle (stopping early at a clean,
// unlocked free entry), then decides the victim, and a sync walks every
// entry one a cycle, then emits the held final writeback; writeback strobes
// come out during the walk. Unused opcodes give no result and stay idle.
module buffer_cache_tag_manager
	import bctm_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input req_t req,
	output logic result_valid,
	output rsp_t result
);

	cmd_t cmd;
	sts_t sts;

	bctm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .opcode(req.opcode),
		.sts(sts), .busy(busy), .cmd(cmd)
	);

	bctm_dp u_dp (
		.clk(clk), .arst_n(arst_n), .req(req), .cmd(cmd), .sts(sts),
		.result_valid(result_valid), .result(result)
	);

endmodule
